// File: design/hpfa_pkg.sv
// ----------------------------------------------------------------------------
// hpfa_pkg: shared types for the binary16 adder
// Carries the per-stage payload structs and a few format constants.
// ----------------------------------------------------------------------------
package hpfa_pkg;

    localparam logic [15:0] DEFAULT_NAN = 16'hFE00;
    localparam logic [15:0] POS_INF = 16'h7C00;

    typedef struct packed {
        logic        special;   // result already decided (NaN / infinity)
        logic [15:0] special_val;
        logic        a_neg;
        logic        b_neg;
        logic [41:0] a_mag;     // magnitude in units of 2^-24
        logic [41:0] b_mag;
        logic        last;
    } hpfa_s1_t;

    typedef struct packed {
        logic        special;
        logic [15:0] special_val;
        logic        neg;       // sign of the sum
        logic        both_neg;
        logic [42:0] mag;       // magnitude of the exact sum
        logic        last;
    } hpfa_s2_t;

    typedef struct packed {
        logic        special;
        logic [15:0] special_val;
        logic        neg;
        logic        both_neg;
        logic [42:0] mag;
        logic [5:0]  msb;       // position of the leading one, 10 when below bit 11
        logic        last;
    } hpfa_s3_t;

endpackage

// File: design/hpfa_round.sv
// ----------------------------------------------------------------------------
// hpfa_round: rounding stage
// Round an exact magnitude to binary16 with ties to even and pack sign.
// ----------------------------------------------------------------------------
module hpfa_round (
    input  hpfa_pkg::hpfa_s3_t s3,
    output logic [15:0]        result
);
    import hpfa_pkg::*;

    logic [5:0]  shift;
    logic [42:0] q;
    logic [42:0] rem;
    logic [42:0] half;
    logic [42:0] q_rnd;
    logic [15:0] bits;
    logic [16:0] packed_sum;

    always_comb begin
        shift = s3.msb - 6'd10;
        q     = s3.mag >> shift;
        rem   = s3.mag & ((43'd1 << shift) - 43'd1);
        half  = (43'd1 << shift) >> 1;
        q_rnd = q;
        if (rem > half || (rem == half && q[0])) begin
            q_rnd = q + 43'd1;
        end
        // mantissa incl. hidden bit adds to exponent field (shift<<10)+q
        packed_sum = ({11'd0, shift} << 10) + {6'd0, q_rnd[10:0]}
                     + {5'd0, q_rnd[11], 11'd0};
        if (s3.mag < 43'd2048) begin
            bits = s3.mag[15:0];
        end else if (packed_sum >= 17'h7C00) begin
            bits = POS_INF;
        end else begin
            bits = packed_sum[15:0];
        end
        if (s3.special) begin
            result = s3.special_val;
        end else if (s3.mag == 43'd0) begin
            result = {s3.both_neg, 15'd0};
        end else begin
            result = {s3.neg, bits[14:0]};
        end
    end

endmodule

// File: design/half_precision_float_adder.sv
// ----------------------------------------------------------------------------
// half_precision_float_adder: streaming IEEE 754 binary16 adder
// Four-stage pipeline: decode, exact add, leading-one search, round.
// ----------------------------------------------------------------------------
// Each input beat carries two binary16 values; each output beat carries their
// correctly rounded sum (nearest, ties to even), subnormals kept. NaN inputs
// come out quieted with the first NaN winning; opposite infinities give
// 0xFE00. A beat enters every cycle while the output is not held, and passes
// through four register stages, the first loaded at acceptance, to m_tvalid.
// The pipeline advances whenever its output stage is empty or being drained,
// so throughput is one beat per cycle; a held output beat freezes every stage
// and drops s_tready in the same cycle. tlast rides along with each beat
// unchanged.
module half_precision_float_adder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] a_half, [31:16] b_half
    input  logic        s_tlast,   // last_element
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] sum_half
    output logic        m_tlast    // last_out
);
    import hpfa_pkg::*;

    logic       v1_reg, v2_reg, v3_reg, v4_reg;
    hpfa_s1_t   s1_reg, s1_next;
    hpfa_s2_t   s2_reg, s2_next;
    hpfa_s3_t   s3_reg, s3_next;
    logic [15:0] out_reg, out_next;
    logic       last4_reg;
    logic       adv;

    // Advance the whole pipe when the output slot is free or being taken.
    assign adv      = !v4_reg || m_tready;
    assign s_tready = adv;

    function automatic logic [41:0] mag_of(input logic [15:0] h);
        logic [41:0] m;
        begin
            if (h[14:10] == 5'd0) begin
                m = {32'd0, h[9:0]};
            end else begin
                m = {31'd0, 1'b1, h[9:0]} << (h[14:10] - 5'd1);
            end
            return m;
        end
    endfunction

    // Stage 1: decode specials and scale to integers.
    always_comb begin
        logic [15:0] a, b;
        logic a_nan, b_nan, a_inf, b_inf;
        a = s_tdata[15:0];
        b = s_tdata[31:16];
        a_nan = (a[14:10] == 5'h1F) && (a[9:0] != 10'd0);
        b_nan = (b[14:10] == 5'h1F) && (b[9:0] != 10'd0);
        a_inf = (a[14:0] == 15'h7C00);
        b_inf = (b[14:0] == 15'h7C00);
        s1_next.special = a_nan || b_nan || a_inf || b_inf;
        priority if (a_nan) begin
            s1_next.special_val = a | 16'h0200;
        end else if (b_nan) begin
            s1_next.special_val = b | 16'h0200;
        end else if (a_inf && b_inf && (a[15] != b[15])) begin
            s1_next.special_val = DEFAULT_NAN;
        end else if (a_inf) begin
            s1_next.special_val = a;
        end else begin
            s1_next.special_val = b;
        end
        s1_next.a_neg = a[15];
        s1_next.b_neg = b[15];
        s1_next.a_mag = mag_of(a);
        s1_next.b_mag = mag_of(b);
        s1_next.last  = s_tlast;
    end

    // Stage 2: exact signed add of magnitudes.
    always_comb begin
        logic [42:0] am, bm;
        am = {1'b0, s1_reg.a_mag};
        bm = {1'b0, s1_reg.b_mag};
        s2_next.special     = s1_reg.special;
        s2_next.special_val = s1_reg.special_val;
        s2_next.both_neg    = s1_reg.a_neg && s1_reg.b_neg;
        s2_next.last        = s1_reg.last;
        if (s1_reg.a_neg == s1_reg.b_neg) begin
            s2_next.mag = am + bm;
            s2_next.neg = s1_reg.a_neg;
        end else if (am >= bm) begin
            s2_next.mag = am - bm;
            s2_next.neg = s1_reg.a_neg;
        end else begin
            s2_next.mag = bm - am;
            s2_next.neg = s1_reg.b_neg;
        end
    end

    // Stage 3: leading-one position.
    always_comb begin
        s3_next.special     = s2_reg.special;
        s3_next.special_val = s2_reg.special_val;
        s3_next.neg         = s2_reg.neg;
        s3_next.both_neg    = s2_reg.both_neg;
        s3_next.mag         = s2_reg.mag;
        s3_next.last        = s2_reg.last;
        s3_next.msb         = 6'd10;
        for (int i = 11; i < 43; i++) begin
            if (s2_reg.mag[i]) begin
                s3_next.msb = 6'(i);
            end
        end
    end

    // Stage 4: round and pack.
    hpfa_round u_round (
        .s3     (s3_reg),
        .result (out_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg    <= s1_next;
            s2_reg    <= s2_next;
            s3_reg    <= s3_next;
            out_reg   <= out_next;
            last4_reg <= s3_reg.last;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = out_reg;
    assign m_tlast  = last4_reg;

    // Hold the output beat while stalled.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed under stall");
    // Check that an empty output never stalls the pipe and that a stage-3 beat reaches the output.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("pipe stalled with empty output");
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && v3_reg |=> m_tvalid)
        else $error("stage 3 beat lost");

endmodule

// File: tb/half_precision_float_adder_tb.sv
// ----------------------------------------------------------------------------
// half_precision_float_adder_tb: self-checking bench for the binary16 adder
// Streams directed and random operand pairs through the block, predicts each
// sum in the bench, and compares every output beat in order.
// ----------------------------------------------------------------------------
module half_precision_float_adder_tb;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [15:0] a_half, [31:16] b_half
    logic        s_tlast;   // last_element
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [15:0] sum_half
    logic        m_tlast;   // last_out

    typedef struct packed {
        logic [15:0] a_half;
        logic [15:0] b_half;
        logic        last_element;
    } operand_beat_t;

    typedef struct packed {
        logic [15:0] sum_half;
        logic        last_out;
    } sum_beat_t;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 12;

    operand_beat_t pending_ops[$];
    sum_beat_t     expected_sums[$];
    int            send_idle_pct;
    int            recv_stall_pct;
    bit            hold_sender;
    int            error_count;
    int            quiet_cycles;
    bit            timed_out;
    bit            stim_done;

    // Sampled handshake, so the falling-edge driver sees what the edge saw.
    logic s_tready_q;

    half_precision_float_adder u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Predictor: exact sum in units of 2^-24, rounded once to nearest even.
    // ------------------------------------------------------------------------
    function automatic logic signed [63:0] half_to_units(logic [15:0] h);
        logic [4:0]  e;
        logic [63:0] mag;
        e = h[14:10];
        if (e == 5'd0)
            mag = {54'd0, h[9:0]};
        else
            mag = {53'd0, 1'b1, h[9:0]} << (e - 5'd1);
        return h[15] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic [15:0] round_units(logic [63:0] m);
        int          p;
        int          shift;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] bits;
        if (m < 64'd2048)
            return m[15:0];
        p = 0;
        while (p < 63 && (m >> (p + 1)) != 0)
            p++;
        shift = p - 10;
        q = m >> shift;
        rem = m & ((64'd1 << shift) - 64'd1);
        half = 64'd1 << (shift - 1);
        if (rem > half || (rem == half && q[0]))
            q = q + 64'd1;
        bits = (64'(shift) << 10) + q;
        if (bits >= 64'h7C00)
            bits = 64'h7C00;
        return bits[15:0];
    endfunction

    function automatic logic [15:0] predict_sum(logic [15:0] a, logic [15:0] b);
        logic signed [63:0] s;
        bit a_nan;
        bit b_nan;
        bit a_inf;
        bit b_inf;
        a_nan = (a[14:10] == 5'h1F) && (a[9:0] != 0);
        b_nan = (b[14:10] == 5'h1F) && (b[9:0] != 0);
        a_inf = (a[14:0] == 15'h7C00);
        b_inf = (b[14:0] == 15'h7C00);
        // Quiet the first NaN seen.
        if (a_nan) return a | 16'h0200;
        if (b_nan) return b | 16'h0200;
        if (a_inf) begin
            if (b_inf && (a[15] != b[15])) return hpfa_pkg::DEFAULT_NAN;
            return a;
        end
        if (b_inf) return b;
        s = half_to_units(a) + half_to_units(b);
        // Exact zero is negative only for two negative zeros.
        if (s == 0) return {a[15] & b[15], 15'd0};
        if (s < 0) return 16'h8000 | round_units(-s);
        return round_units(s);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: present a beat from the pending queue at the falling edge.
    // Advance only when the current beat was taken at the last rising edge.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (s_tvalid && s_tready_q) begin
                // beat taken; pop it and decide on the next
                void'(pending_ops.pop_front());
            end
            if (!(s_tvalid && !s_tready_q)) begin
                if (pending_ops.size() != 0 && !hold_sender &&
                    $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {pending_ops[0].b_half, pending_ops[0].a_half};
                    s_tlast  <= pending_ops[0].last_element;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: on each accepted input beat, queue the predicted sum; on each
    // accepted output beat, compare it with the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        sum_beat_t want;
        s_tready_q <= s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_sums.push_back({predict_sum(s_tdata[15:0], s_tdata[31:16]),
                                         s_tlast});
            end
            if (m_tvalid && m_tready) begin
                if (expected_sums.size() == 0) begin
                    $error("output beat with no sum pending: sum_half %h", m_tdata);
                    error_count++;
                end else begin
                    want = expected_sums.pop_front();
                    if (m_tdata !== want.sum_half) begin
                        $error("sum_half expected %h actual %h", want.sum_half, m_tdata);
                        error_count++;
                    end
                    if (m_tlast !== want.last_out) begin
                        $error("last_out expected %b actual %b", want.last_out, m_tlast);
                        error_count++;
                    end
                end
            end
            // Watchdog: count cycles with no beat accepted on either side.
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_op(logic [15:0] a, logic [15:0] b, logic last);
        pending_ops.push_back({a, b, last});
    endtask

    // Random halves, half of them with a forced exponent: specials, subnormals, boundaries.
    function automatic logic [15:0] pick_half();
        logic [15:0] h;
        h = 16'($urandom);
        case ($urandom_range(7))
            0: h[14:10] = 5'h1F;
            1: h[14:10] = 5'h00;
            2: h[14:10] = 5'($urandom_range(1, 2));
            3: h[14:10] = 5'($urandom_range(28, 30));
            default: ;
        endcase
        return h;
    endfunction

    task automatic wait_drained();
        while (pending_ops.size() != 0 || s_tvalid || expected_sums.size() != 0)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial begin
        logic [15:0] a;
        logic [15:0] b;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        s_tready_q = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_sender = 1'b0;
        error_count = 0;
        quiet_cycles = 0;
        stim_done = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: zeros, infinities, NaNs, overflow, subnormals, ties.
        queue_op(16'h0000, 16'h0000, 1'b0);
        queue_op(16'h8000, 16'h8000, 1'b0);
        queue_op(16'h8000, 16'h0000, 1'b0);
        queue_op(16'h3C00, 16'hBC00, 1'b0);
        queue_op(16'h7C00, 16'hFC00, 1'b0);
        queue_op(16'hFC00, 16'hFC00, 1'b0);
        queue_op(16'h7C00, 16'h3C00, 1'b0);
        queue_op(16'h4000, 16'hFC00, 1'b0);
        queue_op(16'h7C01, 16'h7E55, 1'b0);
        queue_op(16'h3C00, 16'hFD23, 1'b0);
        queue_op(16'hFFFF, 16'h7C00, 1'b0);
        queue_op(16'h7BFF, 16'h7BFF, 1'b0);
        queue_op(16'hFBFF, 16'hFBFF, 1'b0);
        queue_op(16'h7BFF, 16'h5000, 1'b0);
        queue_op(16'h0001, 16'h0001, 1'b0);
        queue_op(16'h03FF, 16'h0001, 1'b0);
        queue_op(16'h8001, 16'h0002, 1'b0);
        queue_op(16'h3C00, 16'h1000, 1'b0);
        queue_op(16'h3C00, 16'h1001, 1'b0);
        queue_op(16'h3C01, 16'h1000, 1'b0);
        queue_op(16'hFFFF, 16'hFFFF, 1'b1);
        queue_op(16'h0400, 16'h8001, 1'b1);
        wait_drained();

        // Random phases: none, sender idle, receiver stall, both.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 73 : (ph == 3) ? 36 : 0;
            recv_stall_pct = (ph == 2) ? 73 : (ph == 3) ? 36 : 0;
            for (int i = 0; i < 232; i++) begin
                a = pick_half();
                b = ($urandom_range(3) == 0) ? 16'((a ^ 16'h8000) ^ $urandom_range(3))
                                             : pick_half();
                queue_op(a, b, $urandom_range(7) == 0);
            end
            // Stall phase: after half the beats, hold the sender until every queued sum has come back.
            if (ph == 2) begin
                while (pending_ops.size() > 116)
                    @(posedge aclk);
                hold_sender = 1'b1;
                while (s_tvalid || expected_sums.size() != 0)
                    @(posedge aclk);
                hold_sender = 1'b0;
            end
            wait_drained();
        end
        stim_done = 1'b1;
    end

    initial begin
        timed_out = 1'b0;
        @(posedge aclk);
        while (!(stim_done && pending_ops.size() == 0 && !s_tvalid &&
                 expected_sums.size() == 0)) begin
            @(posedge aclk);
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                timed_out = 1'b1;
                break;
            end
        end
        if (timed_out) begin
            $display("RESULT: ERROR");
        end else begin
            repeat (DRAIN_CYCLES) @(posedge aclk);
            if (error_count == 0 && expected_sums.size() == 0)
                $display("RESULT: OK");
            else
                $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: half_precision_float_adder.f
design/hpfa_pkg.sv
design/hpfa_round.sv
design/half_precision_float_adder.sv
tb/half_precision_float_adder_tb.sv
